>>> sv/gmspc_pkg.sv
// Package with the types and constants of the best-score path counter.
package gmspc_pkg;

  localparam int MAX_SIDE_DEFAULT = 128;

  localparam int SCORE_W = 12;
  localparam int COUNT_W = 30;
  localparam int DIGIT_W = 4;
  localparam int KIND_W  = 2;
  localparam int SIZE_W  = 8;

  localparam logic [COUNT_W-1:0] PATH_MOD    = COUNT_W'(1000000007);
  localparam logic [SCORE_W-1:0] SCORE_MAX   = '1;
  localparam logic [DIGIT_W-1:0] DIGIT_MAX   = DIGIT_W'(9);
  localparam logic [SIZE_W-1:0]  SIZE_RESET  = SIZE_W'(2);
  localparam logic [SIZE_W-1:0]  SIZE_MIN    = SIZE_W'(2);

  typedef enum logic [KIND_W-1:0] {
    KIND_DIGIT    = 2'd0,
    KIND_START    = 2'd1,
    KIND_END      = 2'd2,
    KIND_OBSTACLE = 2'd3
  } cell_kind_t;

  typedef struct packed {
    logic [SCORE_W-1:0] score;
    logic [COUNT_W-1:0] count;
  } cell_t;

endpackage

>>> sv/grid_max_score_path_count.sv
// Streaming best-score path counter for a square board, one cell per cycle while the result output does not stall.
//
// Cells of an N by N board arrive in reverse raster order, bottom-right cell first and
// top-left cell last, one transfer per cell; N is set by cfg_wr_data (clamped to 2..MAX_SIDE)
// and must be written only between transfers (not enforced by the block). A cell is accepted
// every cycle unless the top-left cell waits in the compute stage for an untaken result. Each
// cell is registered with the row-buffer entry below it; its score and count are formed in the
// next cycle from that entry and the left and diagonal neighbour registers, in a single
// compare-and-add step. The row buffer, a MAX_SIDE-entry memory with one read and one write per
// cycle, needs no clearing pass after reset. One result (best digit sum and best-path count mod
// 1000000007, both zero if the end is unreachable) is registered from the top-left cell and held until taken.
module grid_max_score_path_count #(
  parameter int MAX_SIDE = gmspc_pkg::MAX_SIDE_DEFAULT
) (
  input  logic                         clk,
  input  logic                         rst,
  input  logic                         cfg_wr_en,
  input  logic [gmspc_pkg::SIZE_W-1:0] cfg_wr_data,
  input  logic                         in_valid,
  output logic                         in_stall,
  input  logic [gmspc_pkg::KIND_W-1:0] cell_kind,
  input  logic [gmspc_pkg::DIGIT_W-1:0] digit,
  output logic                         out_valid,
  input  logic                         out_stall,
  output logic [gmspc_pkg::SCORE_W-1:0] max_score,
  output logic [gmspc_pkg::COUNT_W-1:0] path_count
);
  import gmspc_pkg::*;

  localparam int CW     = (MAX_SIDE > 1) ? $clog2(MAX_SIDE) : 1;
  localparam int SIDE_W = $clog2(MAX_SIDE + 1);
  localparam int NW     = (SIDE_W > SIZE_W) ? SIDE_W : SIZE_W;

  logic [SIZE_W-1:0] grid_size;
  logic [NW-1:0]     side;
  logic [CW-1:0]     column_counter;
  logic [CW-1:0]     row_counter;
  logic              in_fire;
  logic              in_last_col;
  logic              in_last_row;

  cell_t             row_store [MAX_SIDE];
  cell_t             below_rd;
  cell_t             left_cell;
  cell_t             diagonal_cell;

  logic              a_valid;
  cell_kind_t        a_kind;
  logic [DIGIT_W-1:0] a_digit;
  logic [CW-1:0]     a_col;
  logic              a_first;
  logic              a_col_nz;
  logic              a_row_nz;
  logic              a_last_col;
  logic              a_last_row;
  logic              a_emit;
  logic              a_adv;

  cell_t             below;
  cell_t             cur;
  logic              use_b;
  logic              use_l;
  logic              use_d;
  logic              any_nb;
  logic [SCORE_W-1:0] best;
  logic [COUNT_W-1:0] cnt_b;
  logic [COUNT_W-1:0] cnt_l;
  logic [COUNT_W-1:0] cnt_d;
  logic [COUNT_W:0]   sum1_raw;
  logic [COUNT_W-1:0] sum1;
  logic [COUNT_W:0]   sum2_raw;
  logic [COUNT_W-1:0] sum2;
  logic [DIGIT_W-1:0] add;
  logic [SCORE_W:0]   score_sum;

  always_comb begin
    logic [NW-1:0] g;
    g = NW'(grid_size);
    if (g < NW'(SIZE_MIN)) begin
      side = NW'(SIZE_MIN);
    end else if (g > NW'(MAX_SIDE)) begin
      side = NW'(MAX_SIDE);
    end else begin
      side = g;
    end
  end

  assign in_last_col = (NW'(column_counter) + NW'(1)) >= side;
  assign in_last_row = (NW'(row_counter) + NW'(1)) >= side;
  assign in_fire     = in_valid && !in_stall;

  assign a_emit   = a_last_col && a_last_row;
  assign a_adv    = a_valid && (!a_emit || !out_valid || !out_stall);
  assign in_stall = a_valid && !a_adv;

  always_comb begin
    below  = a_row_nz ? below_rd : '0;
    use_b  = a_row_nz && (below.count != '0);
    use_l  = a_col_nz && (left_cell.count != '0);
    use_d  = a_col_nz && a_row_nz && (diagonal_cell.count != '0);
    any_nb = use_b || use_l || use_d;

    best = '0;
    if (use_b && below.score > best) begin
      best = below.score;
    end
    if (use_l && left_cell.score > best) begin
      best = left_cell.score;
    end
    if (use_d && diagonal_cell.score > best) begin
      best = diagonal_cell.score;
    end

    cnt_b = (use_b && below.score == best) ? below.count : '0;
    cnt_l = (use_l && left_cell.score == best) ? left_cell.count : '0;
    cnt_d = (use_d && diagonal_cell.score == best) ? diagonal_cell.count : '0;

    sum1_raw = {1'b0, cnt_b} + {1'b0, cnt_l};
    sum1 = (sum1_raw >= {1'b0, PATH_MOD}) ? COUNT_W'(sum1_raw - {1'b0, PATH_MOD})
                                          : sum1_raw[COUNT_W-1:0];
    sum2_raw = {1'b0, sum1} + {1'b0, cnt_d};
    sum2 = (sum2_raw >= {1'b0, PATH_MOD}) ? COUNT_W'(sum2_raw - {1'b0, PATH_MOD})
                                          : sum2_raw[COUNT_W-1:0];

    if (a_kind == KIND_DIGIT) begin
      add = (a_digit > DIGIT_MAX) ? DIGIT_MAX : a_digit;
    end else begin
      add = '0;
    end
    score_sum = {1'b0, best} + (SCORE_W + 1)'(add);

    cur = '0;
    if (a_first) begin
      cur.count = COUNT_W'(1);
    end else if ((a_kind == KIND_DIGIT || a_kind == KIND_END) && any_nb && sum2 != '0) begin
      cur.score = (score_sum > {1'b0, SCORE_MAX}) ? SCORE_MAX : score_sum[SCORE_W-1:0];
      cur.count = sum2;
    end
  end

  always_ff @(posedge clk) begin
    if (in_fire) begin
      below_rd <= row_store[column_counter];
    end
    if (a_adv) begin
      row_store[a_col] <= cur;
    end
  end

  always_ff @(posedge clk) begin
    if (in_fire) begin
      a_kind     <= cell_kind_t'(cell_kind);
      a_digit    <= digit;
      a_col      <= column_counter;
      a_first    <= (column_counter == '0) && (row_counter == '0);
      a_col_nz   <= column_counter != '0;
      a_row_nz   <= row_counter != '0;
      a_last_col <= in_last_col;
      a_last_row <= in_last_row;
    end
    if (a_adv && a_emit) begin
      max_score  <= cur.score;
      path_count <= cur.count;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      grid_size      <= SIZE_RESET;
      column_counter <= '0;
      row_counter    <= '0;
      a_valid        <= 1'b0;
      left_cell      <= '0;
      diagonal_cell  <= '0;
      out_valid      <= 1'b0;
    end else begin
      if (cfg_wr_en) begin
        grid_size <= cfg_wr_data;
      end
      if (in_fire) begin
        if (!in_last_col) begin
          column_counter <= column_counter + CW'(1);
        end else begin
          column_counter <= '0;
          row_counter    <= in_last_row ? '0 : row_counter + CW'(1);
        end
      end
      if (in_fire) begin
        a_valid <= 1'b1;
      end else if (a_adv) begin
        a_valid <= 1'b0;
      end
      if (a_adv) begin
        left_cell     <= a_last_col ? '0 : cur;
        diagonal_cell <= a_last_col ? '0 : below;
      end
      if (a_adv && a_emit) begin
        out_valid <= 1'b1;
      end else if (!out_stall) begin
        out_valid <= 1'b0;
      end
    end
  end

`ifndef ASSERT_OFF
  assert property (@(posedge clk) disable iff (rst) out_valid |-> path_count < PATH_MOD)
    else $error("Path count left the modulo range.");
  assert property (@(posedge clk) disable iff (rst) !a_valid |-> !in_stall)
    else $error("Input stalled with an empty compute stage.");
  assert property (@(posedge clk) disable iff (rst)
    $rose(out_valid) |-> $past(a_valid && a_last_col && a_last_row))
    else $error("Result produced by a cell other than the top-left one.");
  assert property (@(posedge clk) disable iff (rst) left_cell.count < PATH_MOD)
    else $error("Left neighbour count left the modulo range.");
`endif

endmodule
